// ----- src/i2crm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C register master package
// Phase codes, transaction stages, item kinds and operations.
// ----------------------------------------------------------------------------
package i2crm_pkg;

  typedef enum logic [4:0] {
    PH_IDLE, PH_START1, PH_START2, PH_BITLOW, PH_BITHIGH, PH_BITTAIL,
    PH_ACKREL, PH_ACKHIGH, PH_ACKPOLL, PH_WAITDATA, PH_RDLOW, PH_RDHIGH,
    PH_MACKLOW, PH_MACKHIGH, PH_STOP1, PH_STOP2
  } phase_t;

  typedef enum logic [1:0] {ST_ADDR_W, ST_REG, ST_ADDR_R, ST_DATA} stage_t;

  localparam logic [1:0] KIND_CMD  = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_PROBE = 2'd2;

  localparam logic [1:0] CFG_ACK_TIMEOUT  = 2'd0;
  localparam logic [1:0] CFG_PHASE_LENGTH = 2'd1;

  localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] op;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] length;
    logic [7:0] write_byte;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       need_data;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       last;
    logic       done_res;
    logic       status;
  } result_t;

endpackage

// ----- src/i2crm_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C register master core
// Bus sequencer: takes one registered item per cycle when stepped and computes the next
// bus state and the result for that item.
// ----------------------------------------------------------------------------
module i2crm_core
  import i2crm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  item_t      item,
  input  logic [7:0] ack_timeout,
  input  logic [7:0] phase_length,
  output result_t    res
);

  phase_t      phase, phase_next;
  stage_t      stage, stage_next;
  logic [2:0]  bit_count, bit_count_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [1:0]  current_op, current_op_next;
  logic [6:0]  target_addr, target_addr_next;
  logic [7:0]  target_reg, target_reg_next;
  logic [7:0]  wait_count, wait_count_next;
  logic [9:0]  phase_ticks, phase_ticks_next;
  logic        scl, scl_next, sda, sda_next;
  logic        nack_flag, nack_flag_next;
  logic [9:0]  unit;
  logic [9:0]  ticks_dec;
  logic        rv, rl, rd;
  logic [7:0]  rb;

  assign unit = (phase_length == 8'd0) ? 10'd1 : {2'b00, phase_length};

  always_comb begin
    phase_next = phase; stage_next = stage; bit_count_next = bit_count;
    shift_byte_next = shift_byte; bytes_left_next = bytes_left;
    current_op_next = current_op; target_addr_next = target_addr;
    target_reg_next = target_reg; wait_count_next = wait_count;
    phase_ticks_next = phase_ticks; scl_next = scl; sda_next = sda;
    nack_flag_next = nack_flag;
    rv = 1'b0; rl = 1'b0; rd = 1'b0; rb = 8'd0;
    ticks_dec = (phase_ticks != 10'd0) ? phase_ticks - 10'd1 : phase_ticks;

    case (item.kind)
      KIND_CMD: begin
        if (phase == PH_IDLE && item.op != 2'd3) begin
          current_op_next = item.op; target_addr_next = item.dev_addr;
          target_reg_next = item.reg_addr; bytes_left_next = item.length;
          wait_count_next = 8'd0; nack_flag_next = 1'b0; stage_next = ST_ADDR_W;
          sda_next = 1'b1; scl_next = 1'b1;
          phase_next = PH_START1; phase_ticks_next = {unit[7:0], 2'b00};
        end
      end
      KIND_DATA: begin
        if (phase == PH_WAITDATA) begin
          stage_next = ST_DATA; bit_count_next = 3'd0; scl_next = 1'b0;
          sda_next = item.write_byte[7];
          shift_byte_next = {item.write_byte[6:0], 1'b0};
          phase_next = PH_BITLOW; phase_ticks_next = {unit[8:0], 1'b0};
        end
      end
      KIND_TICK: begin
        if (phase == PH_ACKPOLL) begin
          // Low SDA is an ACK; a missed ACK on register or address+R bytes
          // is treated the same as an ACK.
          if (item.sda_in == 1'b0 || wait_count >= ack_timeout) begin
            if (item.sda_in != 1'b0 && (stage == ST_ADDR_W || stage == ST_DATA)) begin
              nack_flag_next = 1'b1; scl_next = 1'b0; sda_next = 1'b0;
              phase_next = PH_STOP1; phase_ticks_next = {unit[7:0], 2'b00};
            end else begin
              scl_next = 1'b0;
              case (stage)
                ST_ADDR_W: begin
                  if (current_op == OP_PROBE) begin
                    sda_next = 1'b0;
                    phase_next = PH_STOP1; phase_ticks_next = {unit[7:0], 2'b00};
                  end else begin
                    stage_next = ST_REG; bit_count_next = 3'd0;
                    sda_next = target_reg[7];
                    shift_byte_next = {target_reg[6:0], 1'b0};
                    phase_next = PH_BITLOW; phase_ticks_next = {unit[8:0], 1'b0};
                  end
                end
                ST_REG: begin
                  if (current_op == OP_WRITE) begin
                    if (bytes_left == 8'd0) begin
                      sda_next = 1'b0;
                      phase_next = PH_STOP1; phase_ticks_next = {unit[7:0], 2'b00};
                    end else begin
                      phase_next = PH_WAITDATA;
                    end
                  end else begin
                    stage_next = ST_ADDR_R; sda_next = 1'b1; scl_next = 1'b1;
                    phase_next = PH_START1; phase_ticks_next = {unit[7:0], 2'b00};
                  end
                end
                ST_ADDR_R: begin
                  sda_next = (bytes_left == 8'd0) ? 1'b0 : 1'b1;
                  bit_count_next = (bytes_left == 8'd0) ? bit_count : 3'd0;
                  shift_byte_next = (bytes_left == 8'd0) ? shift_byte : 8'd0;
                  phase_next = (bytes_left == 8'd0) ? PH_STOP1 : PH_RDLOW;
                  phase_ticks_next = (bytes_left == 8'd0) ? {unit[7:0], 2'b00}
                                                          : {unit[8:0], 1'b0};
                end
                default: begin
                  if (bytes_left <= 8'd1) begin
                    bytes_left_next = 8'd0; sda_next = 1'b0;
                    phase_next = PH_STOP1; phase_ticks_next = {unit[7:0], 2'b00};
                  end else begin
                    bytes_left_next = bytes_left - 8'd1;
                    phase_next = PH_WAITDATA;
                  end
                end
              endcase
            end
          end else begin
            wait_count_next = wait_count + 8'd1;
          end
        end else if (phase != PH_IDLE && phase != PH_WAITDATA) begin
          phase_ticks_next = ticks_dec;
          if (ticks_dec == 10'd0) begin
            case (phase)
              PH_START1: begin
                sda_next = 1'b0; phase_next = PH_START2;
                phase_ticks_next = {unit[7:0], 2'b00};
              end
              PH_START2: begin
                scl_next = 1'b0; bit_count_next = 3'd0;
                sda_next = target_addr[6];
                shift_byte_next = {target_addr[5:0], (stage == ST_ADDR_R), 1'b0};
                phase_next = PH_BITLOW; phase_ticks_next = {unit[8:0], 1'b0};
              end
              PH_BITLOW: begin
                scl_next = 1'b1; phase_next = PH_BITHIGH;
                phase_ticks_next = {unit[8:0], 1'b0};
              end
              PH_BITHIGH: begin
                scl_next = 1'b0; phase_next = PH_BITTAIL;
                phase_ticks_next = {unit[8:0], 1'b0};
              end
              PH_BITTAIL: begin
                if (bit_count == 3'd7) begin
                  sda_next = 1'b1; phase_next = PH_ACKREL; phase_ticks_next = unit;
                end else begin
                  bit_count_next = bit_count + 3'd1;
                  sda_next = shift_byte[7];
                  shift_byte_next = {shift_byte[6:0], 1'b0};
                  phase_next = PH_BITLOW; phase_ticks_next = {unit[8:0], 1'b0};
                end
              end
              PH_ACKREL: begin
                scl_next = 1'b1; wait_count_next = 8'd0;
                phase_next = PH_ACKHIGH; phase_ticks_next = unit;
              end
              PH_ACKHIGH: phase_next = PH_ACKPOLL;
              PH_RDLOW: begin
                scl_next = 1'b1;
                shift_byte_next = {shift_byte[6:0], item.sda_in};
                if (bit_count == 3'd7) begin
                  rv = 1'b1; rb = {shift_byte[6:0], item.sda_in};
                  rl = (bytes_left == 8'd1);
                end
                phase_next = PH_RDHIGH; phase_ticks_next = unit;
              end
              PH_RDHIGH: begin
                scl_next = 1'b0;
                if (bit_count == 3'd7) begin
                  sda_next = (bytes_left <= 8'd1);
                  phase_next = PH_MACKLOW;
                end else begin
                  bit_count_next = bit_count + 3'd1;
                  phase_next = PH_RDLOW;
                end
                phase_ticks_next = {unit[8:0], 1'b0};
              end
              PH_MACKLOW: begin
                scl_next = 1'b1; phase_next = PH_MACKHIGH;
                phase_ticks_next = {unit[8:0], 1'b0};
              end
              PH_MACKHIGH: begin
                scl_next = 1'b0;
                if (bytes_left <= 8'd1) begin
                  bytes_left_next = 8'd0; sda_next = 1'b0;
                  phase_next = PH_STOP1; phase_ticks_next = {unit[7:0], 2'b00};
                end else begin
                  bytes_left_next = bytes_left - 8'd1;
                  sda_next = 1'b1; bit_count_next = 3'd0; shift_byte_next = 8'd0;
                  phase_next = PH_RDLOW; phase_ticks_next = {unit[8:0], 1'b0};
                end
              end
              PH_STOP1: begin
                scl_next = 1'b1; sda_next = 1'b1; phase_next = PH_STOP2;
                phase_ticks_next = {unit[7:0], 2'b00};
              end
              PH_STOP2: begin
                phase_next = PH_IDLE; rd = 1'b1;
              end
              default: phase_next = PH_IDLE;
            endcase
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE; stage <= ST_ADDR_W; bit_count <= 3'd0;
      shift_byte <= 8'd0; bytes_left <= 8'd0; current_op <= 2'd0;
      target_addr <= 7'd0; target_reg <= 8'd0; wait_count <= 8'd0;
      phase_ticks <= 10'd0; scl <= 1'b1; sda <= 1'b1; nack_flag <= 1'b0;
    end else if (step) begin
      phase <= phase_next; stage <= stage_next; bit_count <= bit_count_next;
      shift_byte <= shift_byte_next; bytes_left <= bytes_left_next;
      current_op <= current_op_next; target_addr <= target_addr_next;
      target_reg <= target_reg_next; wait_count <= wait_count_next;
      phase_ticks <= phase_ticks_next; scl <= scl_next; sda <= sda_next;
      nack_flag <= nack_flag_next;
    end
  end

  always_comb begin
    res.scl_level  = scl_next;
    res.sda_level  = sda_next;
    res.busy_res   = (phase_next != PH_IDLE);
    res.need_data  = (phase_next == PH_WAITDATA);
    res.read_valid = rv;
    res.read_byte  = rb;
    res.last       = rl;
    res.done_res   = rd;
    res.status     = rd & nack_flag_next;
  end

endmodule

// ----- src/i2c_register_master_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C register master top level
// Input register, bus sequencer and output register with configuration port.
// ----------------------------------------------------------------------------
// Every item (command, write byte or tick) yields exactly one result. An item
// is taken into an input register, handled by the sequencer once the output
// register is free, and its result is held in an output register; one item per
// clock is sustained while out_stall is low, and a waiting result does not block
// a new transfer as long as the output register is emptied in the same cycle.
module i2c_register_master_top
  import i2crm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] kind,
  input  logic [1:0] op,
  input  logic [6:0] dev_addr,
  input  logic [7:0] reg_addr,
  input  logic [7:0] length,
  input  logic [7:0] write_byte,
  input  logic       sda_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       scl_level,
  output logic       sda_level,
  output logic       busy_res,
  output logic       need_data,
  output logic       read_valid,
  output logic [7:0] read_byte,
  output logic       last,
  output logic       done_res,
  output logic       status,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic [7:0] ack_timeout, phase_length;
  item_t      item;
  logic       item_valid;
  result_t    res, res_reg;
  logic       step, out_free;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign step      = item_valid && out_free;
  assign in_stall  = item_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_timeout  <= ACK_TIMEOUT_RESET;
      phase_length <= 8'd1;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_ACK_TIMEOUT) ack_timeout <= cfg_data;
      else if (cfg_index == CFG_PHASE_LENGTH) phase_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= '{kind, op, dev_addr, reg_addr, length, write_byte, sda_in};
    end
  end

  i2crm_core u_core (
    .clk, .rst, .step, .item, .ack_timeout, .phase_length, .res
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) res_reg <= res;
  end

  assign scl_level  = res_reg.scl_level;
  assign sda_level  = res_reg.sda_level;
  assign busy_res   = res_reg.busy_res;
  assign need_data  = res_reg.need_data;
  assign read_valid = res_reg.read_valid;
  assign read_byte  = res_reg.read_byte;
  assign last       = res_reg.last;
  assign done_res   = res_reg.done_res;
  assign status     = res_reg.status;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C register master testbench
// Drives commands, write bytes and bus ticks through the item channel and
// checks every result against a cycle-free model of the bus sequencer.
// Several register settings are covered, including the extreme ACK timeouts and a zero phase length.
// ----------------------------------------------------------------------------
module testbench;
  import i2crm_pkg::*;

  typedef struct {
    phase_t     ph;
    stage_t     stg;
    logic [2:0] bitc;
    logic [7:0] shf;
    logic [7:0] left;
    logic [1:0] cop;
    logic [6:0] addr;
    logic [7:0] regb;
    logic [7:0] waitc;
    int         ticks;
    logic       scl;
    logic       sda;
    logic       nack;
    logic [7:0] ato;
    logic [7:0] plen;
  } bus_model_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  item_t drv = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  result_t got;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  bus_model_t bus_pred;
  bus_model_t bus_plan;
  item_t pending[$];
  result_t expected_res[$];
  logic in_taken = 1'b0;
  int errors = 0;
  int results_seen = 0;
  int gap_cnt = 0;
  int calm_cnt = 0;
  int stall_cnt = 0;
  bit held_long = 0;
  int items_added = 0;

  i2c_register_master_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(drv.kind), .op(drv.op), .dev_addr(drv.dev_addr), .reg_addr(drv.reg_addr),
    .length(drv.length), .write_byte(drv.write_byte), .sda_in(drv.sda_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .scl_level(got.scl_level), .sda_level(got.sda_level), .busy_res(got.busy_res),
    .need_data(got.need_data), .read_valid(got.read_valid), .read_byte(got.read_byte),
    .last(got.last), .done_res(got.done_res), .status(got.status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // ---------------- bus sequencer model ----------------

  function automatic void reset_bus(output bus_model_t s);
    s.ph = PH_IDLE;
    s.stg = ST_ADDR_W;
    s.bitc = '0;
    s.shf = '0;
    s.left = '0;
    s.cop = '0;
    s.addr = '0;
    s.regb = '0;
    s.waitc = '0;
    s.ticks = 0;
    s.scl = 1'b1;
    s.sda = 1'b1;
    s.nack = 1'b0;
    s.ato = ACK_TIMEOUT_RESET;
    s.plen = 8'd1;
  endfunction

  function automatic void wait_units(inout bus_model_t s, input phase_t p, input int u);
    s.ph = p;
    s.ticks = u * ((s.plen == 0) ? 1 : int'(s.plen));
  endfunction

  function automatic void start_cond(inout bus_model_t s);
    s.sda = 1'b1;
    s.scl = 1'b1;
    wait_units(s, PH_START1, 4);
  endfunction

  function automatic void stop_cond(inout bus_model_t s);
    s.scl = 1'b0;
    s.sda = 1'b0;
    wait_units(s, PH_STOP1, 4);
  endfunction

  function automatic void put_bit(inout bus_model_t s);
    s.sda = s.shf[7];
    s.shf = s.shf << 1;
    wait_units(s, PH_BITLOW, 2);
  endfunction

  function automatic void send_byte(inout bus_model_t s, input logic [7:0] b);
    s.shf = b;
    s.bitc = '0;
    s.scl = 1'b0;
    put_bit(s);
  endfunction

  function automatic void next_write(inout bus_model_t s);
    if (s.left == 0) stop_cond(s);
    else s.ph = PH_WAITDATA;
  endfunction

  function automatic void next_read(inout bus_model_t s);
    if (s.left == 0) begin
      stop_cond(s);
    end else begin
      s.scl = 1'b0;
      s.sda = 1'b1;
      s.bitc = '0;
      s.shf = '0;
      wait_units(s, PH_RDLOW, 2);
    end
  endfunction

  function automatic void ack_seen(inout bus_model_t s);
    case (s.stg)
      ST_ADDR_W: begin
        if (s.cop == OP_PROBE) begin
          stop_cond(s);
        end else begin
          s.stg = ST_REG;
          send_byte(s, s.regb);
        end
      end
      ST_REG: begin
        if (s.cop == OP_WRITE) begin
          next_write(s);
        end else begin
          s.stg = ST_ADDR_R;
          start_cond(s);
        end
      end
      ST_ADDR_R: next_read(s);
      default: begin
        if (s.left > 0) s.left--;
        next_write(s);
      end
    endcase
  endfunction

  function automatic void bus_step(inout bus_model_t s, input item_t it, output result_t r);
    r = '0;
    if (it.kind == KIND_CMD) begin
      if (s.ph == PH_IDLE && it.op <= OP_PROBE) begin
        s.cop = it.op;
        s.addr = it.dev_addr;
        s.regb = it.reg_addr;
        s.left = it.length;
        s.waitc = '0;
        s.nack = 1'b0;
        s.stg = ST_ADDR_W;
        start_cond(s);
      end
    end else if (it.kind == KIND_DATA) begin
      if (s.ph == PH_WAITDATA) begin
        s.stg = ST_DATA;
        send_byte(s, it.write_byte);
      end
    end else if (it.kind == KIND_TICK) begin
      if (s.ph == PH_ACKPOLL) begin
        if (!it.sda_in) begin
          s.scl = 1'b0;
          ack_seen(s);
        end else if (s.waitc >= s.ato) begin
          // Missing ACK only aborts after the write address or a data byte.
          if (s.stg == ST_ADDR_W || s.stg == ST_DATA) begin
            s.nack = 1'b1;
            stop_cond(s);
          end else begin
            s.scl = 1'b0;
            ack_seen(s);
          end
        end else begin
          s.waitc++;
        end
      end else if (s.ph != PH_IDLE && s.ph != PH_WAITDATA) begin
        if (s.ticks > 0) s.ticks--;
        if (s.ticks == 0) begin
          case (s.ph)
            PH_START1: begin
              s.sda = 1'b0;
              wait_units(s, PH_START2, 4);
            end
            PH_START2: begin
              s.scl = 1'b0;
              send_byte(s, {s.addr, s.stg == ST_ADDR_R});
            end
            PH_BITLOW: begin
              s.scl = 1'b1;
              wait_units(s, PH_BITHIGH, 2);
            end
            PH_BITHIGH: begin
              s.scl = 1'b0;
              wait_units(s, PH_BITTAIL, 2);
            end
            PH_BITTAIL: begin
              if (s.bitc == 3'd7) begin
                s.sda = 1'b1;
                wait_units(s, PH_ACKREL, 1);
              end else begin
                s.bitc++;
                put_bit(s);
              end
            end
            PH_ACKREL: begin
              s.scl = 1'b1;
              s.waitc = '0;
              wait_units(s, PH_ACKHIGH, 1);
            end
            PH_ACKHIGH: s.ph = PH_ACKPOLL;
            PH_RDLOW: begin
              s.scl = 1'b1;
              s.shf = {s.shf[6:0], it.sda_in};
              if (s.bitc == 3'd7) begin
                r.read_valid = 1'b1;
                r.read_byte = s.shf;
                r.last = (s.left == 1);
              end
              wait_units(s, PH_RDHIGH, 1);
            end
            PH_RDHIGH: begin
              s.scl = 1'b0;
              if (s.bitc == 3'd7) begin
                s.sda = (s.left <= 1);
                wait_units(s, PH_MACKLOW, 2);
              end else begin
                s.bitc++;
                wait_units(s, PH_RDLOW, 2);
              end
            end
            PH_MACKLOW: begin
              s.scl = 1'b1;
              wait_units(s, PH_MACKHIGH, 2);
            end
            PH_MACKHIGH: begin
              s.scl = 1'b0;
              if (s.left > 0) s.left--;
              next_read(s);
            end
            PH_STOP1: begin
              s.scl = 1'b1;
              s.sda = 1'b1;
              wait_units(s, PH_STOP2, 4);
            end
            PH_STOP2: begin
              s.ph = PH_IDLE;
              r.done_res = 1'b1;
              r.status = s.nack;
            end
            default: s.ph = PH_IDLE;
          endcase
        end
      end
    end
    r.scl_level = s.scl;
    r.sda_level = s.sda;
    r.busy_res = (s.ph != PH_IDLE);
    r.need_data = (s.ph == PH_WAITDATA);
  endfunction

  // ---------------- stimulus construction ----------------

  function automatic item_t rand_item(input logic [1:0] k);
    item_t it;
    it.kind = k;
    it.op = 2'($urandom_range(0, 3));
    it.dev_addr = 7'($urandom);
    it.reg_addr = 8'($urandom);
    it.length = 8'($urandom);
    it.write_byte = 8'($urandom);
    it.sda_in = 1'($urandom);
    return it;
  endfunction

  task automatic add_item(input item_t it);
    result_t dummy;
    bus_step(bus_plan, it, dummy);
    pending.push_back(it);
    items_added++;
  endtask

  // Mode 0: device mostly answers, 1: flaky, 2: absent.
  task automatic run_txn(input logic [1:0] op, input logic [6:0] a, input logic [7:0] rg,
                         input logic [7:0] len, input int mode);
    item_t it;
    it = rand_item(KIND_CMD);
    it.op = op;
    it.dev_addr = a;
    it.reg_addr = rg;
    it.length = len;
    add_item(it);
    while (bus_plan.ph != PH_IDLE) begin
      if ($urandom_range(0, 99) < 3) begin
        // Noise: commands while busy, stray data, unused kind and op codes.
        it = rand_item(2'($urandom_range(0, 3)));
        if (it.kind == KIND_TICK) it.kind = 2'd3;
        add_item(it);
      end else if (bus_plan.ph == PH_WAITDATA) begin
        add_item(rand_item(KIND_DATA));
      end else begin
        it = rand_item(KIND_TICK);
        if (bus_plan.ph == PH_ACKPOLL) begin
          case (mode)
            0: it.sda_in = ($urandom_range(0, 9) == 0);
            1: it.sda_in = ($urandom_range(0, 1) == 0);
            default: it.sda_in = 1'b1;
          endcase
        end
        add_item(it);
      end
    end
    repeat ($urandom_range(0, 2)) add_item(rand_item(2'($urandom_range(0, 3))));
  endtask

  task automatic random_txns(input int n_items);
    int mode;
    int stop_at;
    stop_at = items_added + n_items;
    while (items_added < stop_at) begin
      mode = ($urandom_range(0, 9) == 0) ? 2 : ($urandom_range(0, 4) == 0) ? 1 : 0;
      run_txn(2'($urandom_range(0, 2)), 7'($urandom), 8'($urandom),
              ($urandom_range(0, 9) == 0) ? 8'($urandom_range(4, 15))
                                          : 8'($urandom_range(0, 3)), mode);
    end
  endtask

  task automatic settle;
    do @(posedge clk);
    while (pending.size() != 0 || in_valid || expected_res.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_ACK_TIMEOUT) bus_plan.ato = val;
    else bus_plan.plen = val;
  endtask

  // ---------------- driver ----------------

  always @(negedge clk) begin
    if (!rst && !(in_valid && !in_taken)) begin
      if (gap_cnt > 0) begin
        gap_cnt <= gap_cnt - 1;
        in_valid <= 1'b0;
      end else if (pending.size() != 0) begin
        drv <= pending.pop_front();
        in_valid <= 1'b1;
        if (calm_cnt > 0) begin
          calm_cnt <= calm_cnt - 1;
        end else if ($urandom_range(0, 99) < 2) begin
          calm_cnt <= 150;
        end else begin
          case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6: gap_cnt <= $urandom_range(1, 3);
            7: gap_cnt <= $urandom_range(10, 40);
            default: gap_cnt <= 0;
          endcase
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------- receiver stall ----------------

  always @(negedge clk) begin
    int n;
    n = stall_cnt;
    if (n == 0 && !held_long && results_seen >= 400) begin
      // One long hold so the block backs up and stalls its input.
      n = 300;
      held_long = 1;
    end else if (n == 0) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3: n = $urandom_range(1, 3);
        4: n = $urandom_range(10, 30);
        default: n = 0;
      endcase
    end
    out_stall <= (n > 0);
    stall_cnt <= (n > 0) ? n - 1 : 0;
  end

  // ---------------- prediction and checking ----------------

  task automatic check_field(input string name, input int e, input int a);
    if (e != a) begin
      $display("%0t: mismatch %s expected %0d actual %0d", $time, name, e, a);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    result_t r;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_ACK_TIMEOUT) bus_pred.ato = cfg_data;
        else if (cfg_index == CFG_PHASE_LENGTH) bus_pred.plen = cfg_data;
      end
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        bus_step(bus_pred, drv, r);
        expected_res.push_back(r);
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_res.size() == 0) begin
          $display("%0t: result transfer with nothing expected", $time);
          errors++;
        end else begin
          r = expected_res.pop_front();
          check_field("scl_level", r.scl_level, got.scl_level);
          check_field("sda_level", r.sda_level, got.sda_level);
          check_field("busy_res", r.busy_res, got.busy_res);
          check_field("need_data", r.need_data, got.need_data);
          check_field("read_valid", r.read_valid, got.read_valid);
          check_field("read_byte", r.read_byte, got.read_byte);
          check_field("last", r.last, got.last);
          check_field("done_res", r.done_res, got.done_res);
          check_field("status", r.status, got.status);
        end
      end
    end
  end

  // ---------------- sequence of phases ----------------

  initial begin
    reset_bus(bus_pred);
    reset_bus(bus_plan);
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed transactions at the reset settings.
    run_txn(OP_PROBE, 7'h7F, 8'h00, 8'd0, 0);
    run_txn(OP_WRITE, 7'h55, 8'h00, 8'd1, 0);
    run_txn(OP_READ, 7'h2A, 8'h55, 8'd1, 1);
    run_txn(2'd3, 7'h11, 8'h22, 8'd3, 0);
    settle();

    write_reg(CFG_ACK_TIMEOUT, 8'd1);
    write_reg(CFG_PHASE_LENGTH, 8'd2);
    random_txns(200);
    settle();

    write_reg(CFG_ACK_TIMEOUT, 8'd255);
    write_reg(CFG_PHASE_LENGTH, 8'd1);
    random_txns(150);
    settle();

    write_reg(CFG_ACK_TIMEOUT, 8'd0);
    write_reg(CFG_PHASE_LENGTH, 8'd0);
    random_txns(150);
    settle();
    repeat (10) @(posedge clk);

    if (errors == 0) begin
      $display("PASS i2c_register_master_top");
    end else begin
      $display("FAIL i2c_register_master_top");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("FAIL i2c_register_master_top");
    $finish;
  end

endmodule

// ----- sim.f -----
src/i2crm_pkg.sv
src/i2crm_core.sv
src/i2c_register_master_top.sv
tb/testbench.sv
